// File: hw/rtl/qrr_pkg.sv
// ----------------------------------------------------------------------------
// qrr_pkg
// Shared types and codes for the quadratic real roots solver.
// ----------------------------------------------------------------------------
`default_nettype none

package qrr_pkg;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_LINEAR = 3'd1,
    KIND_SINGLE = 3'd2,
    KIND_TWO_B0 = 3'd3,
    KIND_TWO    = 3'd4
  } kind_t;

  localparam logic [1:0] CNT_NONE = 2'd0;
  localparam logic [1:0] CNT_ONE  = 2'd1;
  localparam logic [1:0] CNT_TWO  = 2'd2;

endpackage

`default_nettype wire

// File: hw/rtl/qrr_in_if.sv
// ----------------------------------------------------------------------------
// qrr_in_if
// Coefficient channel: valid/ready with a, b, c in signed fixed point.
// ----------------------------------------------------------------------------
`default_nettype none

interface qrr_in_if #(
  parameter int WORD_BITS = 32
) ();
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] coef_a;
  logic signed [WORD_BITS-1:0] coef_b;
  logic signed [WORD_BITS-1:0] coef_c;

  modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
  modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/qrr_out_if.sv
// ----------------------------------------------------------------------------
// qrr_out_if
// Result channel: valid/ready with root count, ordered roots and overflow.
// ----------------------------------------------------------------------------
`default_nettype none

interface qrr_out_if #(
  parameter int WORD_BITS = 32
) ();
  logic                        valid;
  logic                        ready;
  logic [1:0]                  root_count;
  logic signed [WORD_BITS-1:0] root_low;
  logic signed [WORD_BITS-1:0] root_high;
  logic                        overflow;

  modport source (output valid, output root_count, output root_low, output root_high,
                  output overflow, input ready);
  modport sink   (input valid, input root_count, input root_low, input root_high,
                  input overflow, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/qrr_div.sv
// ----------------------------------------------------------------------------
// qrr_div
// Pipelined restoring divider, one quotient bit per stage, QW stages.
// Quotients of 2^QW or more are flagged as big.
// ----------------------------------------------------------------------------
`default_nettype none

module qrr_div #(
  parameter int  NW = 48,
  parameter int  DW = 33,
  parameter int  QW = 32,
  parameter type side_t = logic
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] in_num,
  input  wire logic [DW-1:0] in_den,
  input  side_t              in_side,
  output logic               out_valid,
  output logic [QW-1:0]      out_quo,
  output logic               out_big,
  output side_t              out_side
);

  localparam int XW = ((NW > QW) ? NW : QW) + 1;
  localparam int HW = XW - QW;
  localparam int CW = (HW > DW) ? HW : DW;

  logic [XW-1:0] n_ext;
  logic [CW-1:0] hi_w;
  logic          big0;
  logic [DW-1:0] rem0;

  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] nq_r   [QW];
  logic [DW-1:0] den_r  [QW];
  logic          big_r  [QW];
  side_t         side_r [QW];
  logic [QW-1:0] vld_r;

  logic [DW-1:0] rem_nxt [QW];
  logic [QW-1:0] nq_nxt  [QW];

  assign n_ext = XW'(in_num);
  assign hi_w  = CW'(n_ext[XW-1:QW]);
  assign big0  = hi_w >= CW'(in_den);
  assign rem0  = hi_w[DW-1:0];

  always_comb begin
    logic [DW-1:0] s_rem;
    logic [QW-1:0] s_nq;
    logic [DW-1:0] s_den;
    logic [DW:0]   t;
    logic [DW:0]   diff;
    logic          ge;
    for (int i = 0; i < QW; i++) begin
      if (i == 0) begin
        s_rem = rem0;
        s_nq  = n_ext[QW-1:0];
        s_den = in_den;
      end else begin
        s_rem = rem_r[i-1];
        s_nq  = nq_r[i-1];
        s_den = den_r[i-1];
      end
      t          = {s_rem, s_nq[QW-1]};
      diff       = t - {1'b0, s_den};
      ge         = t >= {1'b0, s_den};
      rem_nxt[i] = ge ? diff[DW-1:0] : t[DW-1:0];
      nq_nxt[i]  = {s_nq[QW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r     <= rem_nxt;
      nq_r      <= nq_nxt;
      den_r[0]  <= in_den;
      big_r[0]  <= big0;
      side_r[0] <= in_side;
      for (int i = 1; i < QW; i++) begin
        den_r[i]  <= den_r[i-1];
        big_r[i]  <= big_r[i-1];
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quo   = nq_r[QW-1];
  assign out_big   = big_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

`default_nettype wire

// File: hw/rtl/qrr_sqrt.sv
// ----------------------------------------------------------------------------
// qrr_sqrt
// Pipelined digit-by-digit integer square root (floor), one root bit per
// stage, KW stages for a 2*KW bit radicand.
// ----------------------------------------------------------------------------
`default_nettype none

module qrr_sqrt #(
  parameter int  KW = 33,
  parameter type side_t = logic
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [2*KW-1:0] in_rad,
  input  side_t                in_side,
  output logic                 out_valid,
  output logic [KW-1:0]        out_root,
  output side_t                out_side
);

  logic [KW+1:0]   rem_r  [KW];
  logic [KW-1:0]   root_r [KW];
  logic [2*KW-1:0] rest_r [KW];
  side_t           side_r [KW];
  logic [KW-1:0]   vld_r;

  logic [KW+1:0]   rem_nxt  [KW];
  logic [KW-1:0]   root_nxt [KW];
  logic [2*KW-1:0] rest_nxt [KW];

  always_comb begin
    logic [KW+1:0]   s_rem;
    logic [KW-1:0]   s_root;
    logic [2*KW-1:0] s_rest;
    logic [KW+3:0]   t;
    logic [KW+3:0]   trial;
    logic [KW+3:0]   diff;
    logic            ge;
    for (int i = 0; i < KW; i++) begin
      if (i == 0) begin
        s_rem  = '0;
        s_root = '0;
        s_rest = in_rad;
      end else begin
        s_rem  = rem_r[i-1];
        s_root = root_r[i-1];
        s_rest = rest_r[i-1];
      end
      t           = {s_rem, s_rest[2*KW-1:2*KW-2]};
      trial       = (KW+4)'({s_root, 2'b01});
      diff        = t - trial;
      ge          = t >= trial;
      rem_nxt[i]  = ge ? diff[KW+1:0] : t[KW+1:0];
      root_nxt[i] = {s_root[KW-2:0], ge};
      rest_nxt[i] = {s_rest[2*KW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[KW-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r     <= rem_nxt;
      root_r    <= root_nxt;
      rest_r    <= rest_nxt;
      side_r[0] <= in_side;
      for (int i = 1; i < KW; i++) begin
        side_r[i] <= side_r[i-1];
      end
    end
  end

  assign out_valid = vld_r[KW-1];
  assign out_root  = root_r[KW-1];
  assign out_side  = side_r[KW-1];

endmodule

`default_nettype wire

// File: hw/rtl/quadratic_real_roots_core.sv
// ----------------------------------------------------------------------------
// quadratic_real_roots_core
// Real roots of a*x^2 + b*x + c in signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes one item (coef_a, coef_b, coef_c) per valid/ready handshake.
//   out_ch gives one item per input: root_count, root_low <= root_high and
//   overflow when a root saturated. No root gives zeros; one root appears in
//   both root fields.
// Pipeline: three front stages (magnitudes, products, discriminant), a
//   2*WORD_BITS stage divider, the WORD_BITS+1 stage square root, a WORD_BITS
//   stage divider pair and the register stages around them.
// Throughput: one item per cycle while not stalled; every stage then takes a new item.
// Stall: the whole pipeline holds while out_ch.valid is high and
//   out_ch.ready low; in_ch.ready then drops. Nothing is lost or repeated.
// Reset: rst_n clears all valid bits; the pipeline comes up empty and ready.
// ----------------------------------------------------------------------------
`default_nettype none

module quadratic_real_roots_core #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  qrr_in_if.sink    in_ch,
  qrr_out_if.source out_ch
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int DA = 2 * W + 2;

  typedef struct packed {
    qrr_pkg::kind_t kind;
    logic           na;
    logic           nb;
    logic           nc;
    logic [W-1:0]   ma;
    logic [W-1:0]   mb;
    logic [W-1:0]   mc;
  } coef_t;

  typedef struct packed {
    coef_t         coef;
    logic [DA-1:0] d;
    logic          neg;
  } a_side_t;

  typedef struct packed {
    coef_t        coef;
    logic [W-1:0] lin_root;
    logic         lin_ovf;
  } m_side_t;

  typedef struct packed {
    coef_t        coef;
    logic [W:0]   r;
    logic [W-1:0] lin_root;
    logic         lin_ovf;
  } b_side_t;

  typedef struct packed {
    logic [W-1:0] val;
    logic         ovf;
  } fit_t;

  function automatic fit_t fit(input logic neg, input logic [W:0] mag, input logic big);
    fit_t       f;
    logic [W:0] lim;
    logic [W:0] m;
    logic [W:0] nm;
    lim   = ((W+1)'(1) << (W - 1)) - (W+1)'(!neg);
    f.ovf = big || (mag > lim);
    m     = f.ovf ? lim : mag;
    nm    = -m;
    f.val = neg ? nm[W-1:0] : m[W-1:0];
    return f;
  endfunction

  logic en;
  logic out_valid_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: signs and magnitudes
  logic         s1_v_r;
  logic         s1_na_r, s1_nb_r, s1_nc_r;
  logic [W-1:0] s1_ma_r, s1_mb_r, s1_mc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_na_r <= in_ch.coef_a[W-1];
      s1_nb_r <= in_ch.coef_b[W-1];
      s1_nc_r <= in_ch.coef_c[W-1];
      s1_ma_r <= in_ch.coef_a[W-1] ? W'(-in_ch.coef_a) : in_ch.coef_a;
      s1_mb_r <= in_ch.coef_b[W-1] ? W'(-in_ch.coef_b) : in_ch.coef_b;
      s1_mc_r <= in_ch.coef_c[W-1] ? W'(-in_ch.coef_c) : in_ch.coef_c;
    end
  end

  // stage 2: products
  logic           s2_v_r;
  logic           s2_na_r, s2_nb_r, s2_nc_r;
  logic [W-1:0]   s2_ma_r, s2_mb_r, s2_mc_r;
  logic [2*W-1:0] s2_bb_r, s2_ac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_na_r <= s1_na_r;
      s2_nb_r <= s1_nb_r;
      s2_nc_r <= s1_nc_r;
      s2_ma_r <= s1_ma_r;
      s2_mb_r <= s1_mb_r;
      s2_mc_r <= s1_mc_r;
      s2_bb_r <= (2*W)'(s1_mb_r) * (2*W)'(s1_mb_r);
      s2_ac_r <= (2*W)'(s1_ma_r) * (2*W)'(s1_mc_r);
    end
  end

  // stage 3: discriminant, case and first divide operands
  localparam int NA = W + 2 * F;

  logic [DA-1:0]  bb_e, ac4, d_sum, d_dif;
  logic           opp, gt, eq;
  qrr_pkg::kind_t kind_nxt;
  logic [NA-1:0]  a_num_nxt;
  logic [W:0]     a_den_nxt;
  logic           a_neg_nxt;

  assign bb_e  = DA'(s2_bb_r);
  assign ac4   = {s2_ac_r, 2'b00};
  assign d_sum = bb_e + ac4;
  assign d_dif = bb_e - ac4;
  assign opp   = (s2_mc_r != '0) && (s2_na_r != s2_nc_r);
  assign gt    = bb_e > ac4;
  assign eq    = bb_e == ac4;

  always_comb begin
    if (s2_ma_r == '0) begin
      kind_nxt = (s2_mb_r != '0) ? qrr_pkg::KIND_LINEAR : qrr_pkg::KIND_NONE;
    end else if (opp || gt) begin
      kind_nxt = (s2_mb_r == '0) ? qrr_pkg::KIND_TWO_B0 : qrr_pkg::KIND_TWO;
    end else if (eq) begin
      kind_nxt = qrr_pkg::KIND_SINGLE;
    end else begin
      kind_nxt = qrr_pkg::KIND_NONE;
    end
  end

  always_comb begin
    unique case (kind_nxt)
      qrr_pkg::KIND_LINEAR: begin
        a_num_nxt = NA'({s2_mc_r, {F{1'b0}}});
        a_den_nxt = {1'b0, s2_mb_r};
        a_neg_nxt = s2_nc_r == s2_nb_r;
      end
      qrr_pkg::KIND_SINGLE: begin
        a_num_nxt = NA'({s2_mb_r, {F{1'b0}}});
        a_den_nxt = {s2_ma_r, 1'b0};
        a_neg_nxt = (s2_mb_r != '0) && (s2_nb_r == s2_na_r);
      end
      default: begin
        a_num_nxt = {s2_mc_r, {(2*F){1'b0}}};
        a_den_nxt = {1'b0, s2_ma_r};
        a_neg_nxt = 1'b0;
      end
    endcase
  end

  logic          s3_v_r;
  a_side_t       s3_side_r;
  logic [NA-1:0] s3_num_r;
  logic [W:0]    s3_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side_r.coef.kind <= kind_nxt;
      s3_side_r.coef.na   <= s2_na_r;
      s3_side_r.coef.nb   <= s2_nb_r;
      s3_side_r.coef.nc   <= s2_nc_r;
      s3_side_r.coef.ma   <= s2_ma_r;
      s3_side_r.coef.mb   <= s2_mb_r;
      s3_side_r.coef.mc   <= s2_mc_r;
      s3_side_r.d         <= opp ? d_sum : d_dif;
      s3_side_r.neg       <= a_neg_nxt;
      s3_num_r            <= a_num_nxt;
      s3_den_r            <= a_den_nxt;
    end
  end

  // first divider: linear root, single root, or -c/a for the b = 0 case
  logic           da_v;
  logic [2*W-1:0] da_q;
  logic           da_big;
  a_side_t        da_side;

  qrr_div #(
    .NW(NA), .DW(W + 1), .QW(2 * W), .side_t(a_side_t)
  ) u_div_a (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(s3_v_r), .in_num(s3_num_r), .in_den(s3_den_r), .in_side(s3_side_r),
    .out_valid(da_v), .out_quo(da_q), .out_big(da_big), .out_side(da_side)
  );

  // mid stage: radicand select and single-root saturation
  fit_t lin_fit;
  assign lin_fit = fit(da_side.neg, da_q[W:0], da_big || (da_q[2*W-1:W+1] != '0));

  logic          m_v_r;
  m_side_t       m_side_r;
  logic [DA-1:0] m_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= da_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_side_r.coef     <= da_side.coef;
      m_side_r.lin_root <= lin_fit.val;
      m_side_r.lin_ovf  <= lin_fit.ovf;
      if (da_side.coef.kind == qrr_pkg::KIND_TWO_B0) begin
        m_rad_r <= da_big ? DA'({(2*W){1'b1}}) : DA'(da_q);
      end else begin
        m_rad_r <= da_side.d;
      end
    end
  end

  logic       sq_v;
  logic [W:0] sq_root;
  m_side_t    sq_side;

  qrr_sqrt #(
    .KW(W + 1), .side_t(m_side_t)
  ) u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(m_v_r), .in_rad(m_rad_r), .in_side(m_side_r),
    .out_valid(sq_v), .out_root(sq_root), .out_side(sq_side)
  );

  // prep stage: temp = |b| + sqrt(delta), operands of the two root divides
  localparam int NB = W + 2 + F;
  localparam int NC = W + F + 1;

  logic [W+1:0] t2;
  assign t2 = (W+2)'(sq_side.coef.mb) + (W+2)'(sq_root);

  logic          p_v_r;
  b_side_t       p_side_r;
  logic [NB-1:0] p_bnum_r;
  logic [W:0]    p_bden_r;
  logic [NC-1:0] p_cnum_r;
  logic [W+1:0]  p_cden_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
    end else if (en) begin
      p_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_side_r.coef     <= sq_side.coef;
      p_side_r.r        <= sq_root;
      p_side_r.lin_root <= sq_side.lin_root;
      p_side_r.lin_ovf  <= sq_side.lin_ovf;
      p_bnum_r          <= {t2, {F{1'b0}}};
      p_bden_r          <= {sq_side.coef.ma, 1'b0};
      p_cnum_r          <= {sq_side.coef.mc, {(F+1){1'b0}}};
      p_cden_r          <= t2;
    end
  end

  logic         db_v;
  logic [W-1:0] db_q, dc_q;
  logic         db_big, dc_big;
  b_side_t      db_side;

  qrr_div #(
    .NW(NB), .DW(W + 1), .QW(W), .side_t(b_side_t)
  ) u_div_b (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(p_v_r), .in_num(p_bnum_r), .in_den(p_bden_r), .in_side(p_side_r),
    .out_valid(db_v), .out_quo(db_q), .out_big(db_big), .out_side(db_side)
  );

  qrr_div #(
    .NW(NC), .DW(W + 2), .QW(W), .side_t(logic)
  ) u_div_c (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(p_v_r), .in_num(p_cnum_r), .in_den(p_cden_r), .in_side(1'b0),
    .out_valid(), .out_quo(dc_q), .out_big(dc_big), .out_side()
  );

  // final stage: saturation, ordering, output register
  fit_t         r1, r2, rn, rp;
  logic         tneg;
  logic [1:0]   cnt_nxt;
  logic [W-1:0] lo_nxt, hi_nxt;
  logic         ovf_nxt;

  assign tneg = !db_side.coef.nb;
  assign r1   = fit(tneg != db_side.coef.na, {1'b0, db_q}, db_big);
  assign r2   = fit((db_side.coef.mc != '0) && (db_side.coef.nc != tneg),
                    {1'b0, dc_q}, dc_big);
  assign rn   = fit(1'b1, db_side.r, 1'b0);
  assign rp   = fit(1'b0, db_side.r, 1'b0);

  always_comb begin
    unique case (db_side.coef.kind)
      qrr_pkg::KIND_LINEAR, qrr_pkg::KIND_SINGLE: begin
        cnt_nxt = qrr_pkg::CNT_ONE;
        lo_nxt  = db_side.lin_root;
        hi_nxt  = db_side.lin_root;
        ovf_nxt = db_side.lin_ovf;
      end
      qrr_pkg::KIND_TWO_B0: begin
        cnt_nxt = qrr_pkg::CNT_TWO;
        lo_nxt  = rn.val;
        hi_nxt  = rp.val;
        ovf_nxt = rn.ovf || rp.ovf;
      end
      qrr_pkg::KIND_TWO: begin
        cnt_nxt = qrr_pkg::CNT_TWO;
        if ($signed(r1.val) < $signed(r2.val)) begin
          lo_nxt = r1.val;
          hi_nxt = r2.val;
        end else begin
          lo_nxt = r2.val;
          hi_nxt = r1.val;
        end
        ovf_nxt = r1.ovf || r2.ovf;
      end
      default: begin
        cnt_nxt = qrr_pkg::CNT_NONE;
        lo_nxt  = '0;
        hi_nxt  = '0;
        ovf_nxt = 1'b0;
      end
    endcase
  end

  logic [1:0]   cnt_r;
  logic [W-1:0] lo_r, hi_r;
  logic         ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= db_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cnt_r <= cnt_nxt;
      lo_r  <= lo_nxt;
      hi_r  <= hi_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.root_count = cnt_r;
  assign out_ch.root_low   = lo_r;
  assign out_ch.root_high  = hi_r;
  assign out_ch.overflow   = ovf_r;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid right after reset");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (cnt_r == qrr_pkg::CNT_NONE) |-> (lo_r == '0) && (hi_r == '0) && !ovf_r)
    else $error("no-root item with nonzero fields");

  a_single_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (cnt_r == qrr_pkg::CNT_ONE) |-> lo_r == hi_r)
    else $error("single root differs between fields");

  a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (cnt_r == qrr_pkg::CNT_TWO) |-> $signed(lo_r) <= $signed(hi_r))
    else $error("roots out of order");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (cnt_r == qrr_pkg::CNT_NONE) || (cnt_r == qrr_pkg::CNT_ONE) ||
                    (cnt_r == qrr_pkg::CNT_TWO))
    else $error("bad root count");

endmodule

`default_nettype wire

// File: tb/tb_quadratic_real_roots_core.sv
// ----------------------------------------------------------------------------
// tb_quadratic_real_roots_core
// Self-checking bench for the quadratic real roots solver. A directed table
// covers zero coefficients, extremes, the linear case, a double root, a
// negative discriminant and saturation; random coefficient sets follow. Every
// result is compared with its table entry or an exact integer predictor. The
// sender works in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_quadratic_real_roots_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam int WB = 32;
  localparam int N_RANDOM = 1430;
  localparam int WATCHDOG = 4000;
  localparam int DRAIN = 4 * WB + 40;

  typedef struct packed {
    logic [1:0]           cnt;
    logic signed [WB-1:0] lo;
    logic signed [WB-1:0] hi;
    logic                 ovf;
  } roots_t;

  typedef struct {
    logic signed [WB-1:0] a;
    logic signed [WB-1:0] b;
    logic signed [WB-1:0] c;
    bit                   known;
    roots_t               res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [WB-1:0] idle_cnt;
  int stall_cnt = 0;
  int errors = 0;
  bit tb_done = 1'b0;
  bit stim_done = 1'b0;
  roots_t pending_roots[$];
  row_t dir_rows[$];

  qrr_in_if #(.WORD_BITS(WB)) in_ch ();
  qrr_out_if #(.WORD_BITS(WB)) out_ch ();

  quadratic_real_roots_core #(.FRAC_BITS(FB), .WORD_BITS(WB)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [127:0] isqrt128(logic [127:0] n);
    logic [63:0] y;
    logic [63:0] t;
    y = '0;
    for (int i = 63; i >= 0; i--) begin
      t = y | (64'd1 << i);
      if (128'(t) * 128'(t) <= n) y = t;
    end
    return 128'(y);
  endfunction

  function automatic logic signed [WB-1:0] sat_root(bit neg, logic [127:0] mag,
                                                    ref bit ovf);
    logic [127:0] lim;
    logic [127:0] m;
    lim = (128'd1 << (WB - 1)) - (neg ? 128'd0 : 128'd1);
    m = mag;
    if (mag > lim) begin
      ovf = 1'b1;
      m = lim;
    end
    return neg ? WB'(-m) : WB'(m);
  endfunction

  function automatic roots_t solve_quadratic(logic signed [WB-1:0] a,
                                             logic signed [WB-1:0] b,
                                             logic signed [WB-1:0] c);
    roots_t r;
    bit na, nb, nc, ovf, tneg;
    logic [127:0] ma, mb, mc, bb, ac4, d, t2;
    logic signed [WB-1:0] r1, r2;
    int sgn;
    na = a[WB-1]; nb = b[WB-1]; nc = c[WB-1];
    ma = 128'($unsigned(na ? -a : a));
    mb = 128'($unsigned(nb ? -b : b));
    mc = 128'($unsigned(nc ? -c : c));
    ovf = 1'b0;
    r = '0;
    if (ma == 0) begin
      if (mb != 0) begin
        r.cnt = qrr_pkg::CNT_ONE;
        r.lo = sat_root(nc == nb, (mc << FB) / mb, ovf);
        r.hi = r.lo;
      end
    end else begin
      bb = mb * mb;
      ac4 = (ma * mc) << 2;
      d = '0;
      if (mc != 0 && na != nc) begin
        d = bb + ac4;
        sgn = 1;
      end else begin
        sgn = (bb > ac4) ? 1 : (bb == ac4) ? 0 : -1;
        if (sgn > 0) d = bb - ac4;
      end
      if (sgn > 0) begin
        r.cnt = qrr_pkg::CNT_TWO;
        if (mb == 0) begin
          t2 = isqrt128((mc << (2 * FB)) / ma);
          r.lo = sat_root(1'b1, t2, ovf);
          r.hi = sat_root(1'b0, t2, ovf);
        end else begin
          t2 = mb + isqrt128(d);
          tneg = !nb;
          r1 = sat_root(tneg != na, (t2 << FB) / (2 * ma), ovf);
          r2 = sat_root(mc != 0 && nc != tneg, (mc << (FB + 1)) / t2, ovf);
          r.lo = (r1 < r2) ? r1 : r2;
          r.hi = (r1 < r2) ? r2 : r1;
        end
      end else if (sgn == 0) begin
        r.cnt = qrr_pkg::CNT_ONE;
        r.lo = sat_root(mb != 0 && nb == na, (mb << FB) / (2 * ma), ovf);
        r.hi = r.lo;
      end
    end
    r.ovf = ovf;
    return r;
  endfunction

  function automatic logic signed [WB-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return WB'($urandom);
      1: return WB'(int'($urandom_range(0, 8 << FB)) - (4 << FB));
      2: return WB'(int'($urandom_range(0, 64)) - 32) <<< FB;
      3: return '0;
      4: return WB'(int'($urandom_range(0, 600)) - 300);
      default: return WB'($urandom) >>> $urandom_range(0, 31);
    endcase
  endfunction

  task automatic add_row(logic signed [WB-1:0] a, logic signed [WB-1:0] b,
                         logic signed [WB-1:0] c, bit known = 0,
                         roots_t res = '0);
    row_t r;
    r.a = a; r.b = b; r.c = c; r.known = known; r.res = res;
    dir_rows.push_back(r);
  endtask

  task automatic send_item(logic signed [WB-1:0] a, logic signed [WB-1:0] b,
                           logic signed [WB-1:0] c, bit known, roots_t res);
    if (idle_cnt != 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle_cnt) @(posedge clk);
      idle_cnt = '0;
    end
    in_ch.valid <= 1'b1;
    in_ch.coef_a <= a;
    in_ch.coef_b <= b;
    in_ch.coef_c <= c;
    pending_roots.push_back(known ? res : solve_quadratic(a, b, c));
    do @(posedge clk); while (!in_ch.ready);
    if ($urandom_range(0, 7) == 0) idle_cnt = WB'($urandom_range(1, 12));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 15) == 0) stall_cnt <= $urandom_range(1, 20);
    end
  end

  always @(posedge clk) begin
    roots_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_roots.size() == 0) begin
        $error("unexpected result item");
        errors++;
      end else begin
        e = pending_roots.pop_front();
        if (out_ch.root_count !== e.cnt) begin
          $error("root_count: expected %0d, got %0d", e.cnt, out_ch.root_count);
          errors++;
        end
        if (out_ch.root_low !== e.lo) begin
          $error("root_low: expected %0d, got %0d", e.lo, out_ch.root_low);
          errors++;
        end
        if (out_ch.root_high !== e.hi) begin
          $error("root_high: expected %0d, got %0d", e.hi, out_ch.root_high);
          errors++;
        end
        if (out_ch.overflow !== e.ovf) begin
          $error("overflow: expected %0d, got %0d", e.ovf, out_ch.overflow);
          errors++;
        end
      end
    end
  end

  // no-progress watchdog
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (!tb_done && rst_n && (!stim_done || pending_roots.size() != 0)) begin
      quiet <= quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  localparam logic signed [WB-1:0] ONE = 1 <<< FB;
  localparam logic signed [WB-1:0] MAXV = {1'b0, {(WB-1){1'b1}}};
  localparam logic signed [WB-1:0] MINV = {1'b1, {(WB-1){1'b0}}};

  initial begin
    in_ch.valid = 1'b0;
    in_ch.coef_a = '0;
    in_ch.coef_b = '0;
    in_ch.coef_c = '0;
    idle_cnt = '0;
    add_row(0, 0, 0, 1, '{qrr_pkg::CNT_NONE, 0, 0, 0});
    add_row(0, 0, MAXV, 1, '{qrr_pkg::CNT_NONE, 0, 0, 0});
    add_row(0, ONE, -2 * ONE, 1, '{qrr_pkg::CNT_ONE, 2 * ONE, 2 * ONE, 0});
    add_row(0, 1, MAXV, 1, '{qrr_pkg::CNT_ONE, MINV, MINV, 1});
    add_row(0, -1, MAXV, 1, '{qrr_pkg::CNT_ONE, MAXV, MAXV, 1});
    add_row(ONE, 0, ONE, 1, '{qrr_pkg::CNT_NONE, 0, 0, 0});
    add_row(ONE, -2 * ONE, ONE, 1, '{qrr_pkg::CNT_ONE, ONE, ONE, 0});
    add_row(ONE, 0, -4 * ONE, 1, '{qrr_pkg::CNT_TWO, -2 * ONE, 2 * ONE, 0});
    add_row(ONE, -3 * ONE, 2 * ONE);
    add_row(-ONE, ONE, 6 * ONE);
    add_row(ONE, 0, 0, 1, '{qrr_pkg::CNT_ONE, 0, 0, 0});
    add_row(ONE, 5 * ONE, 0);
    add_row(MAXV, MAXV, MAXV);
    add_row(MINV, MINV, MINV);
    add_row(MINV, MAXV, MAXV);
    add_row(1, MAXV, 1);
    add_row(1, MINV, MINV);
    add_row(MINV, 0, MAXV);
    add_row(1, 0, MINV);
    add_row(-1, 3, 0);
    add_row(MAXV, 1, -1);
    add_row(-1, -1, -1);
    add_row(ONE, -ONE, 0);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i])
      send_item(dir_rows[i].a, dir_rows[i].b, dir_rows[i].c, dir_rows[i].known,
                dir_rows[i].res);
    for (int i = 0; i < N_RANDOM; i++)
      send_item(rand_coef(), rand_coef(), rand_coef(), 0, '0);
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;
    while (pending_roots.size() != 0) @(posedge clk);
    tb_done = 1'b1;
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
